/* hw/rtl/csem_pkg.sv */
package csem_pkg;

  // Field widths fixed by the request and result formats.
  localparam int IdW    = 8;
  localparam int PrioW  = 8;
  localparam int CountW = 16;
  localparam int WaitW  = 7;
  localparam int MaxW   = 15;

  // Default depth of the wait queue.
  localparam int MAX_WAITERS_DEF = 16;

  // Configuration register indexes.
  localparam logic REG_MAX_COUNT  = 1'b0;
  localparam logic REG_ORDER_MODE = 1'b1;

  // Request types.
  localparam logic REQ_WAIT = 1'b0;
  localparam logic REQ_POST = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_ACQUIRED = 3'd0;
  localparam logic [2:0] ST_BLOCKED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOWAKE   = 3'd3;
  localparam logic [2:0] ST_WOKE     = 3'd4;

  // Operations broadcast to every queue cell.
  localparam logic [2:0] OP_HOLD = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_PROP = 3'd2;
  localparam logic [2:0] OP_INS  = 3'd3;
  localparam logic [2:0] OP_DEQ  = 3'd4;

  typedef struct packed {
    logic [2:0]       op;
    logic             order_mode;
    logic [IdW-1:0]   new_id;
    logic [PrioW-1:0] new_prio;
  } cell_ctl_t;

endpackage

/* hw/rtl/counting_semaphore_wait_queue.sv */
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  req_type, thread_id, thread_priority
// out      output     out_valid / out_stall status, woken_thread_id, count_after,
//                                          waiters_after
// cfg      input      cfg_we               cfg_index, cfg_data
//
// One request at a time. Acquire, reject and post pass through the decide and
// done states; a blocking wait also passes through the scan state, in which the
// mark bit moves one cell per cycle along the queue chain.
// A result held by out_stall stalls the next request only in its done state.
// Synchronous reset: count zero, queue empty, max_count 1, FIFO order.
module counting_semaphore_wait_queue #(
  parameter int MAX_WAITERS = csem_pkg::MAX_WAITERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [csem_pkg::MaxW-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [csem_pkg::IdW-1:0]          thread_id,
  input  logic [csem_pkg::PrioW-1:0]        thread_priority,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic [csem_pkg::IdW-1:0]          woken_thread_id,
  output logic signed [csem_pkg::CountW-1:0] count_after,
  output logic [csem_pkg::WaitW-1:0]        waiters_after
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  localparam int IdW    = csem_pkg::IdW;
  localparam int PrioW  = csem_pkg::PrioW;
  localparam int CountW = csem_pkg::CountW;
  localparam int WaitW  = csem_pkg::WaitW;

  logic [1:0]                state;
  logic [csem_pkg::MaxW-1:0] max_count;
  logic                      order_mode;
  logic signed [CountW-1:0]  sem_count;
  logic [WaitW-1:0]          waiter_count;
  logic [WaitW-1:0]          scan_cnt;

  logic                      req_post;
  logic [IdW-1:0]            req_id;
  logic [PrioW-1:0]          req_prio;

  logic [2:0]                pend_status;
  logic [IdW-1:0]            pend_woken;

  logic signed [CountW:0]    dec_val;
  logic signed [CountW:0]    inc_val;
  logic signed [CountW-1:0]  wait_next;
  logic signed [CountW-1:0]  post_next;
  logic signed [CountW-1:0]  cap_val;
  logic                      queue_full;
  logic                      out_free;

  csem_pkg::cell_ctl_t       ctl;
  logic                      cmark [MAX_WAITERS];
  logic [IdW-1:0]            cid   [MAX_WAITERS];
  logic [PrioW-1:0]          cprio [MAX_WAITERS];

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Saturating count arithmetic for both request types.
  always_comb begin
    dec_val = {sem_count[CountW-1], sem_count} - (CountW+1)'(1);
    inc_val = {sem_count[CountW-1], sem_count} + (CountW+1)'(1);
    cap_val = signed'({1'b0, max_count});
    if (dec_val < -(CountW+1)'(32768)) begin
      wait_next = {1'b1, {(CountW-1){1'b0}}};
    end else begin
      wait_next = dec_val[CountW-1:0];
    end
    if (inc_val > (CountW+1)'(32767)) begin
      post_next = {1'b0, {(CountW-1){1'b1}}};
    end else begin
      post_next = inc_val[CountW-1:0];
    end
    if (post_next > cap_val) begin
      post_next = cap_val;
    end
  end

  assign queue_full = (waiter_count >= WaitW'(MAX_WAITERS));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_count  <= csem_pkg::MaxW'(1);
      order_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        csem_pkg::REG_MAX_COUNT:  max_count  <= cfg_data;
        csem_pkg::REG_ORDER_MODE: order_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_post <= req_type;
      req_id   <= thread_id;
      req_prio <= thread_priority;
    end
  end

  // Cell operation for this cycle.
  always_comb begin
    ctl.op         = csem_pkg::OP_HOLD;
    ctl.order_mode = order_mode;
    ctl.new_id     = req_id;
    ctl.new_prio   = req_prio;
    case (state)
      S_DECIDE: begin
        if (req_post == csem_pkg::REQ_WAIT) begin
          if (wait_next < 0 && !queue_full) begin
            ctl.op = csem_pkg::OP_LOAD;
          end
        end else if (post_next <= 0 && waiter_count != '0) begin
          ctl.op = csem_pkg::OP_DEQ;
        end
      end
      S_SCAN: begin
        ctl.op = (scan_cnt == '0) ? csem_pkg::OP_INS : csem_pkg::OP_PROP;
      end
      default: ctl.op = csem_pkg::OP_HOLD;
    endcase
  end

  // Sequencer and semaphore state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sem_count    <= '0;
      waiter_count <= '0;
      scan_cnt     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          pend_woken <= '0;
          state      <= S_DONE;
          if (req_post == csem_pkg::REQ_WAIT) begin
            if (wait_next >= 0) begin
              sem_count   <= wait_next;
              pend_status <= csem_pkg::ST_ACQUIRED;
            end else if (queue_full) begin
              pend_status <= csem_pkg::ST_FULL;
            end else begin
              sem_count    <= wait_next;
              waiter_count <= waiter_count + WaitW'(1);
              scan_cnt     <= waiter_count;
              pend_status  <= csem_pkg::ST_BLOCKED;
              state        <= S_SCAN;
            end
          end else begin
            sem_count <= post_next;
            if (post_next <= 0 && waiter_count != '0) begin
              waiter_count <= waiter_count - WaitW'(1);
              pend_woken   <= cid[0];
              pend_status  <= csem_pkg::ST_WOKE;
            end else begin
              pend_status <= csem_pkg::ST_NOWAKE;
            end
          end
        end
        S_SCAN: begin
          if (scan_cnt == '0) begin
            state <= S_DONE;
          end else begin
            scan_cnt <= scan_cnt - WaitW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status          <= pend_status;
      woken_thread_id <= pend_woken;
      count_after     <= sem_count;
      waiters_after   <= waiter_count;
    end
  end

  // Chain of queue cells, head at index zero.
  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    logic             left_mark;
    logic [IdW-1:0]   left_id;
    logic [PrioW-1:0] left_prio;
    logic [IdW-1:0]   right_id;
    logic [PrioW-1:0] right_prio;

    if (i == 0) begin : g_head
      assign left_mark = 1'b0;
      assign left_id   = '0;
      assign left_prio = '0;
    end else begin : g_mid
      assign left_mark = cmark[i-1];
      assign left_id   = cid[i-1];
      assign left_prio = cprio[i-1];
    end

    if (i == MAX_WAITERS - 1) begin : g_tail
      assign right_id   = cid[i];
      assign right_prio = cprio[i];
    end else begin : g_body
      assign right_id   = cid[i+1];
      assign right_prio = cprio[i+1];
    end

    csem_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .in_use     (WaitW'(i) < waiter_count),
      .left_mark  (left_mark),
      .left_id    (left_id),
      .left_prio  (left_prio),
      .right_id   (right_id),
      .right_prio (right_prio),
      .mark       (cmark[i]),
      .id         (cid[i]),
      .prio       (cprio[i])
    );
  end

endmodule

/* hw/rtl/csem_cell.sv */
// One slot of the wait queue. A mark bit finds the insert position: it is
// loaded where the new thread may go ahead, then ORed along the chain so
// that the first marked cell is the insert point.
module csem_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  csem_pkg::cell_ctl_t        ctl,
  input  logic                       in_use,
  input  logic                       left_mark,
  input  logic [csem_pkg::IdW-1:0]   left_id,
  input  logic [csem_pkg::PrioW-1:0] left_prio,
  input  logic [csem_pkg::IdW-1:0]   right_id,
  input  logic [csem_pkg::PrioW-1:0] right_prio,
  output logic                       mark,
  output logic [csem_pkg::IdW-1:0]   id,
  output logic [csem_pkg::PrioW-1:0] prio
);

  // Mark bit: set on free slots and, in priority order mode, on slots the new thread outranks.
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= 1'b0;
    end else begin
      case (ctl.op)
        csem_pkg::OP_LOAD: mark <= !in_use || (ctl.order_mode && (ctl.new_prio > prio));
        csem_pkg::OP_PROP: mark <= mark | left_mark;
        default:           mark <= mark;
      endcase
    end
  end

  // Payload: take the new thread, shift toward the tail, or shift toward the head.
  always_ff @(posedge clk) begin
    case (ctl.op)
      csem_pkg::OP_INS: begin
        if (mark && !left_mark) begin
          id   <= ctl.new_id;
          prio <= ctl.new_prio;
        end else if (left_mark) begin
          id   <= left_id;
          prio <= left_prio;
        end
      end
      csem_pkg::OP_DEQ: begin
        id   <= right_id;
        prio <= right_prio;
      end
      default: begin
        id   <= id;
        prio <= prio;
      end
    endcase
  end

endmodule
